// File: hw/rtl/mfmc_pkg.sv
// ----------------------------------------------------------------------------
// mfmc_pkg: shared types and constants for the min-cut edge lister
// Matrix geometry, arithmetic widths, shared-unit opcodes and memory request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfmc_pkg;

	localparam int MAX_NODES  = 16;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int MAT_DEPTH  = MAX_NODES * MAX_NODES;
	localparam int CAP_BITS   = 8;
	localparam int FLOW_W     = CAP_BITS + 1;
	localparam int RES_W      = CAP_BITS + 2;
	localparam int CNT_W      = $clog2(MAX_NODES + 1);
	localparam int NODE_W     = 5;
	localparam int TOTAL_W    = 7;
	localparam int MAX_PAIRS  = 64;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// input operation codes, carried on s_tuser
	localparam logic OP_EDGE  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CAP_BITS-1:0]      cap_t;
	typedef logic signed [FLOW_W-1:0] flow_t;
	typedef logic signed [RES_W-1:0]  res_t;

	typedef enum logic [1:0] {
		ALU_RESID,
		ALU_FLOW_ADD,
		ALU_SAT_INC
	} alu_op_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  cap_we;
		addr_t cap_waddr;
		cap_t  cap_wdata;
		logic  flow_we;
		addr_t flow_waddr;
		flow_t flow_wdata;
	} mat_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfmc_alu.sv
// ----------------------------------------------------------------------------
// mfmc_alu: shared arithmetic unit
// Residual, flow update and saturating capacity increment, with compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfmc_alu (
	input  mfmc_pkg::alu_op_t op,
	input  mfmc_pkg::cap_t    cap,
	input  mfmc_pkg::flow_t   flow,
	input  mfmc_pkg::res_t    operand,
	output mfmc_pkg::res_t    result,
	output logic              pos,
	output logic              below
);
	import mfmc_pkg::*;

	localparam res_t CAP_TOP = res_t'((1 << CAP_BITS) - 1);

	res_t cap_x;
	res_t flow_x;
	res_t inc;

	assign cap_x  = res_t'({2'b00, cap});
	assign flow_x = res_t'({flow[FLOW_W-1], flow});
	assign inc    = cap_x + operand;

	always_comb begin
		unique case (op)
			ALU_RESID:    result = cap_x - flow_x;
			ALU_FLOW_ADD: result = flow_x + operand;
			ALU_SAT_INC:  result = (inc > CAP_TOP) ? CAP_TOP : inc;
			default:      result = cap_x - flow_x;
		endcase
	end

	assign pos   = result > res_t'(0);
	assign below = result < operand;

endmodule

`default_nettype wire

// File: hw/rtl/mfmc_mat.sv
// ----------------------------------------------------------------------------
// mfmc_mat: capacity and flow matrices
// One read and one write port per matrix; capacity entries carry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfmc_mat (
	input  wire                clk,
	input  wire                arst_n,
	input  mfmc_pkg::mat_req_t req,
	output mfmc_pkg::cap_t     cap_rd,
	output mfmc_pkg::flow_t    flow_rd
);
	import mfmc_pkg::*;

	cap_t                 cap_mem  [MAT_DEPTH];
	flow_t                flow_mem [MAT_DEPTH];
	logic [MAT_DEPTH-1:0] cap_vld_q;
	cap_t                 cap_rd_q;
	logic                 vld_rd_q;
	flow_t                flow_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_q <= '0;
		end else if (req.cap_we) begin
			cap_vld_q[req.cap_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.cap_we) begin
			cap_mem[req.cap_waddr] <= req.cap_wdata;
		end
		if (req.flow_we) begin
			flow_mem[req.flow_waddr] <= req.flow_wdata;
		end
		if (req.rd_en) begin
			cap_rd_q  <= cap_mem[req.rd_addr];
			vld_rd_q  <= cap_vld_q[req.rd_addr];
			flow_rd_q <= flow_mem[req.rd_addr];
		end
	end

	// never-written capacity reads as zero
	assign cap_rd  = vld_rd_q ? cap_rd_q : '0;
	assign flow_rd = flow_rd_q;

endmodule

`default_nettype wire

// File: hw/rtl/max_flow_min_cut_edges.sv
// ----------------------------------------------------------------------------
// max_flow_min_cut_edges: min-cut edge lister over a small multigraph
// Edge loads build a capacity matrix; a solve runs breadth-first augmenting
// path max flow from node 1 to the last node and lists the cut pairs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   tdata {end_b, end_a}, tuser operation
//  m_*       out  m_tvalid/tready   tdata {pair_total, cut_to, cut_from},
//                                   tuser pair_valid, tlast last_pair
//  cfg_*     in   cfg_we            cfg_wdata node_count
//
//  An edge transaction reads the entry, writes it and then its mirror (a self
//  loop adds two in one write). A solve clears all 256 flow entries, then per
//  augmenting path runs a search and a path walk, then a counting scan and a
//  listing scan, all through the one matrix read port and the shared
//  arithmetic unit; output stalls add to the listing.
//  Reset clears the capacity valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_flow_min_cut_edges (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [mfmc_pkg::IN_DATA_W-1:0]      s_tdata,   // end_a, end_b
	input  wire  [0:0]                          s_tuser,   // operation
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [mfmc_pkg::OUT_DATA_W-1:0]     m_tdata,   // cut_from, cut_to, pair_total
	output logic [0:0]                          m_tuser,   // pair_valid
	output logic                                m_tlast,
	input  wire                                 cfg_we,
	input  wire  [mfmc_pkg::NODE_W-1:0]         cfg_wdata
);
	import mfmc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_EDGE_RD, S_EDGE_W1, S_EDGE_W2, S_CLR, S_BFS_INIT, S_BFS_POP,
		S_BFS_RD, S_BFS_EV, S_AUG_RD, S_AUG_EV, S_UPD_RD, S_UPD_W1, S_UPD_W2,
		S_SCAN_RD, S_SCAN_EV, S_EMPTY
	} state_t;

	localparam res_t DIFF_MAX = res_t'((1 << (RES_W - 1)) - 1);

	state_t state_q;
	logic [NODE_W-1:0] nc_q;
	idx_t nl_q, a_q, b_q, u_q, v_q, p_q;
	logic [CNT_W-1:0] head_q, tail_q;
	logic [MAX_NODES-1:0] reached_q;
	idx_t parent_q [MAX_NODES];
	idx_t queue_q  [MAX_NODES];
	res_t diff_q;
	flow_t newf_q;
	cap_t capv_q;
	addr_t clr_q;
	logic [TOTAL_W-1:0] cnt_q, total_q;
	logic pass_q;
	logic m_valid_q, pv_q, last_q;
	logic [NODE_W-1:0] from_q, to_q;
	logic [TOTAL_W-1:0] tot_q;

	mat_req_t req;
	cap_t cap_rd;
	flow_t flow_rd;
	alu_op_t alu_op;
	res_t alu_opnd, alu_res;
	logic alu_pos, alu_below;

	logic s_acc, out_free, bfs_hit, scan_hit, a_ok, b_ok;
	logic [NODE_W-1:0] in_a, in_b, a_m1, b_m1, nodes;
	logic [MAX_NODES-1:0] reached_nx;
	logic [CNT_W-1:0] tail_nx;
	idx_t par_v;
	logic q_we;
	idx_t q_widx, q_wval, par_widx, par_wval;

	mfmc_mat u_mat (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cap_rd  (cap_rd),
		.flow_rd (flow_rd)
	);

	mfmc_alu u_alu (
		.op      (alu_op),
		.cap     (cap_rd),
		.flow    (flow_rd),
		.operand (alu_opnd),
		.result  (alu_res),
		.pos     (alu_pos),
		.below   (alu_below)
	);

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_a     = s_tdata[NODE_W-1:0];
	assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
	assign a_m1     = in_a - NODE_W'(1);
	assign b_m1     = in_b - NODE_W'(1);
	assign a_ok     = (in_a != '0) && (in_a <= NODE_W'(MAX_NODES));
	assign b_ok     = (in_b != '0) && (in_b <= NODE_W'(MAX_NODES));
	assign nodes    = (nc_q < NODE_W'(2)) ? NODE_W'(2) :
	                  (nc_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : nc_q;
	assign out_free = !m_valid_q || m_tready;
	assign par_v    = parent_q[v_q];

	assign bfs_hit  = (state_q == S_BFS_EV) && !reached_q[v_q] && alu_pos &&
	                  (tail_q < CNT_W'(MAX_NODES));
	assign reached_nx = reached_q | (MAX_NODES'(bfs_hit) << v_q);
	assign tail_nx    = tail_q + CNT_W'(bfs_hit);
	assign scan_hit = reached_q[u_q] && !reached_q[v_q] && (cap_rd != '0) &&
	                  (cnt_q < TOTAL_W'(MAX_PAIRS));

	always_comb begin
		req      = '0;
		alu_op   = ALU_RESID;
		alu_opnd = diff_q;
		q_we     = 1'b0;
		q_widx   = tail_q[IDX_W-1:0];
		q_wval   = v_q;
		par_widx = v_q;
		par_wval = u_q;
		unique case (state_q)
			S_EDGE_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {a_q, b_q};
			end
			S_EDGE_W1: begin
				alu_op        = ALU_SAT_INC;
				alu_opnd      = (a_q == b_q) ? res_t'(2) : res_t'(1);
				req.cap_we    = 1'b1;
				req.cap_waddr = {a_q, b_q};
				req.cap_wdata = alu_res[CAP_BITS-1:0];
			end
			S_EDGE_W2: begin
				req.cap_we    = 1'b1;
				req.cap_waddr = {b_q, a_q};
				req.cap_wdata = capv_q;
			end
			S_CLR: begin
				req.flow_we    = 1'b1;
				req.flow_waddr = clr_q;
			end
			S_BFS_INIT: begin
				q_we     = 1'b1;
				q_widx   = '0;
				q_wval   = '0;
				par_widx = '0;
				par_wval = '0;
			end
			S_BFS_RD, S_SCAN_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {u_q, v_q};
			end
			S_BFS_EV: q_we = bfs_hit;
			S_AUG_RD, S_UPD_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {par_v, v_q};
			end
			S_UPD_W1: begin
				alu_op         = ALU_FLOW_ADD;
				req.flow_we    = 1'b1;
				req.flow_waddr = {p_q, v_q};
				req.flow_wdata = alu_res[FLOW_W-1:0];
			end
			S_UPD_W2: begin
				req.flow_we    = 1'b1;
				req.flow_waddr = {v_q, p_q};
				req.flow_wdata = -newf_q;
			end
			default: ;
		endcase
	end

	// search queue and parent links share the enqueue strobe
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_q[q_widx]    <= q_wval;
			parent_q[par_widx] <= par_wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nc_q      <= NODE_W'(MAX_NODES);
			nl_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			u_q       <= '0;
			v_q       <= '0;
			p_q       <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			reached_q <= '0;
			diff_q    <= '0;
			newf_q    <= '0;
			capv_q    <= '0;
			clr_q     <= '0;
			cnt_q     <= '0;
			total_q   <= '0;
			pass_q    <= 1'b0;
			m_valid_q <= 1'b0;
			pv_q      <= 1'b0;
			last_q    <= 1'b0;
			from_q    <= '0;
			to_q      <= '0;
			tot_q     <= '0;
		end else begin
			if (cfg_we) begin
				nc_q <= cfg_wdata;
			end
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						a_q <= a_m1[IDX_W-1:0];
						b_q <= b_m1[IDX_W-1:0];
						if (s_tuser[0] == OP_SOLVE) begin
							nl_q    <= idx_t'(nodes - NODE_W'(1));
							clr_q   <= '0;
							state_q <= S_CLR;
						end else if (a_ok && b_ok) begin
							state_q <= S_EDGE_RD;
						end
					end
				end
				S_EDGE_RD: state_q <= S_EDGE_W1;
				S_EDGE_W1: begin
					capv_q  <= alu_res[CAP_BITS-1:0];
					state_q <= (a_q == b_q) ? S_IDLE : S_EDGE_W2;
				end
				S_EDGE_W2: state_q <= S_IDLE;
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_BFS_INIT;
					end
				end
				S_BFS_INIT: begin
					reached_q <= MAX_NODES'(1);
					head_q    <= '0;
					tail_q    <= CNT_W'(1);
					state_q   <= S_BFS_POP;
				end
				S_BFS_POP: begin
					u_q     <= queue_q[head_q[IDX_W-1:0]];
					head_q  <= head_q + CNT_W'(1);
					v_q     <= '0;
					state_q <= S_BFS_RD;
				end
				S_BFS_RD: state_q <= S_BFS_EV;
				S_BFS_EV: begin
					reached_q <= reached_nx;
					tail_q    <= tail_nx;
					if (v_q != nl_q) begin
						v_q     <= v_q + IDX_W'(1);
						state_q <= S_BFS_RD;
					end else if (head_q < tail_nx) begin
						state_q <= S_BFS_POP;
					end else if (reached_nx[nl_q]) begin
						v_q     <= nl_q;
						diff_q  <= DIFF_MAX;
						state_q <= S_AUG_RD;
					end else begin
						u_q     <= '0;
						v_q     <= '0;
						cnt_q   <= '0;
						pass_q  <= 1'b0;
						state_q <= S_SCAN_RD;
					end
				end
				S_AUG_RD: begin
					p_q     <= par_v;
					state_q <= S_AUG_EV;
				end
				S_AUG_EV: begin
					// keep the bottleneck residual along the path
					if (alu_below) begin
						diff_q <= alu_res;
					end
					if (p_q == '0) begin
						v_q     <= nl_q;
						state_q <= S_UPD_RD;
					end else begin
						v_q     <= p_q;
						state_q <= S_AUG_RD;
					end
				end
				S_UPD_RD: begin
					p_q     <= par_v;
					state_q <= S_UPD_W1;
				end
				S_UPD_W1: begin
					newf_q  <= alu_res[FLOW_W-1:0];
					state_q <= S_UPD_W2;
				end
				S_UPD_W2: begin
					v_q     <= p_q;
					state_q <= (p_q == '0) ? S_BFS_INIT : S_UPD_RD;
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (!pass_q || !scan_hit || out_free) begin
						if (scan_hit) begin
							cnt_q <= cnt_q + TOTAL_W'(1);
						end
						if (pass_q && scan_hit) begin
							m_valid_q <= 1'b1;
							from_q    <= NODE_W'(u_q) + NODE_W'(1);
							to_q      <= NODE_W'(v_q) + NODE_W'(1);
							tot_q     <= total_q;
							pv_q      <= 1'b1;
							last_q    <= (cnt_q + TOTAL_W'(1)) == total_q;
						end
						state_q <= S_SCAN_RD;
						if (v_q != nl_q) begin
							v_q <= v_q + IDX_W'(1);
						end else begin
							v_q <= '0;
							if (u_q != nl_q) begin
								u_q <= u_q + IDX_W'(1);
							end else if (pass_q) begin
								state_q <= S_IDLE;
							end else begin
								total_q <= cnt_q + TOTAL_W'(scan_hit);
								cnt_q   <= '0;
								u_q     <= '0;
								pass_q  <= 1'b1;
								if ((cnt_q + TOTAL_W'(scan_hit)) == '0) begin
									state_q <= S_EMPTY;
								end
							end
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						from_q    <= '0;
						to_q      <= '0;
						tot_q     <= '0;
						pv_q      <= 1'b0;
						last_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2*NODE_W - TOTAL_W){1'b0}}, tot_q, to_q, from_q};
	assign m_tuser  = pv_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/mfmc_chk.sv
// ----------------------------------------------------------------------------
// mfmc_chk: port-level checks for the min-cut edge lister
// Output stability and consistency of the cut pair transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfmc_chk (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [mfmc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire [0:0]                        m_tuser,
	input wire                              m_tlast
);
	import mfmc_pkg::*;

	// hold a stalled transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[16:0] == '0))
		else $error("empty-cut item malformed");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[16:10] != '0))
		else $error("real pair with zero total");

	a_sides: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[4:0] != m_tdata[9:5]) &&
			(m_tdata[4:0] != '0) && (m_tdata[9:5] != '0))
		else $error("cut pair endpoints invalid");

endmodule

bind max_flow_min_cut_edges mfmc_chk u_mfmc_chk (.*);

`default_nettype wire

// File: tb/max_flow_min_cut_edges_checker.sv
// ----------------------------------------------------------------------------
// max_flow_min_cut_edges_checker: cut-pair predictor and result comparator
// Watches the edge/solve input channel and the config port, keeps its own
// capacity matrix, runs breadth-first augmenting-path max flow on each solve
// and compares every output transaction against the oldest predicted pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_flow_min_cut_edges_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [15:0] s_tdata,   // end_a, end_b
	input  wire  [0:0]  s_tuser,   // operation
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [23:0] m_tdata,   // cut_from, cut_to, pair_total
	input  wire  [0:0]  m_tuser,   // pair_valid
	input  wire         m_tlast,
	input  wire         cfg_we,
	input  wire  [4:0]  cfg_wdata,
	output int          mismatches,
	output int          pending,
	output int          pairs_seen,
	output int          solves_seen
);
	import mfmc_pkg::*;

	typedef struct packed {
		logic [4:0] cut_from;
		logic [4:0] cut_to;
		logic [6:0] pair_total;
		logic       pair_valid;
		logic       last_pair;
	} cut_pair_t;

	cut_pair_t  cut_pairs_due[$];
	logic [4:0] nodes_reg;
	int         cap_mat [MAX_NODES][MAX_NODES];

	assign pending = cut_pairs_due.size();

	function automatic int nodes_in_use();
		if (nodes_reg < 2) return 2;
		if (nodes_reg > MAX_NODES) return MAX_NODES;
		return nodes_reg;
	endfunction

	task automatic add_edge_unit(input int a, input int b);
		if (cap_mat[a][b] < (1 << CAP_BITS) - 1) cap_mat[a][b]++;
	endtask

	// append one predicted result to the tail of the due list
	task automatic expect_pair(input cut_pair_t pr);
		cut_pairs_due.insert(cut_pairs_due.size(), pr);
	endtask

	task automatic predict_cut();
		int flow [MAX_NODES][MAX_NODES];
		int par [MAX_NODES];
		int fifo [MAX_NODES];
		bit seen [MAX_NODES];
		int n, head, tail, u, v, p, bottleneck, cnt;
		cut_pair_t pr;
		cut_pair_t found[$];
		n = nodes_in_use();
		foreach (flow[i, j]) flow[i][j] = 0;
		forever begin
			foreach (seen[i]) seen[i] = 0;
			seen[0] = 1; fifo[0] = 0; par[0] = 0; head = 0; tail = 1;
			while (head < tail) begin
				u = fifo[head++];
				for (v = 0; v < n; v++) begin
					if (!seen[v] && cap_mat[u][v] - flow[u][v] > 0 && tail < MAX_NODES) begin
						seen[v] = 1; par[v] = u; fifo[tail++] = v;
					end
				end
			end
			if (!seen[n-1]) break;
			bottleneck = 1 << 30;
			for (v = n - 1; v != 0; v = p) begin
				p = par[v];
				if (cap_mat[p][v] - flow[p][v] < bottleneck) bottleneck = cap_mat[p][v] - flow[p][v];
			end
			for (v = n - 1; v != 0; v = p) begin
				p = par[v];
				flow[p][v] += bottleneck;
				flow[v][p] -= bottleneck;
			end
		end
		for (u = 0; u < n; u++)
			for (v = 0; v < n; v++)
				if (found.size() < MAX_PAIRS && seen[u] && !seen[v] && cap_mat[u][v] != 0) begin
					pr = '0;
					pr.cut_from = 5'(u + 1);
					pr.cut_to = 5'(v + 1);
					pr.pair_valid = 1'b1;
					found.insert(found.size(), pr);
				end
		cnt = found.size();
		if (cnt == 0) begin
			pr = '0;
			pr.last_pair = 1'b1;
			expect_pair(pr);
		end else begin
			foreach (found[i]) begin
				found[i].pair_total = 7'(cnt);
				found[i].last_pair = (i == cnt - 1);
				expect_pair(found[i]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cut_pair_t got, want;
		int a, b;
		if (!arst_n) begin
			nodes_reg <= 5'd16;
			foreach (cap_mat[i, j]) cap_mat[i][j] = 0;
			cut_pairs_due.delete();
			mismatches <= 0;
			pairs_seen <= 0;
			solves_seen <= 0;
		end else begin
			if (cfg_we) nodes_reg <= cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_EDGE) begin
					a = s_tdata[4:0];
					b = s_tdata[9:5];
					if (a >= 1 && a <= MAX_NODES && b >= 1 && b <= MAX_NODES) begin
						add_edge_unit(a - 1, b - 1);
						add_edge_unit(b - 1, a - 1);
					end
				end else begin
					predict_cut();
					solves_seen <= solves_seen + 1;
				end
			end
			if (m_tvalid && m_tready) begin
				got.cut_from = m_tdata[4:0];
				got.cut_to = m_tdata[9:5];
				got.pair_total = m_tdata[16:10];
				got.pair_valid = m_tuser[0];
				got.last_pair = m_tlast;
				pairs_seen <= pairs_seen + 1;
				if (cut_pairs_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result from=%0d to=%0d total=%0d",
							$realtime, got.cut_from, got.cut_to, got.pair_total);
					mismatches <= mismatches + 1;
				end else begin
					want = cut_pairs_due.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: exp %0d>%0d t%0d v%0d l%0d got %0d>%0d t%0d v%0d l%0d",
								$realtime, want.cut_from, want.cut_to, want.pair_total,
								want.pair_valid, want.last_pair, got.cut_from, got.cut_to,
								got.pair_total, got.pair_valid, got.last_pair);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/max_flow_min_cut_edges_test.sv
// ----------------------------------------------------------------------------
// max_flow_min_cut_edges_test: stimulus and verdict for the min-cut lister
// Loads random and directed multigraphs at several node counts, solves them
// under random source and sink stalls plus one long output hold-off, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_flow_min_cut_edges_test;
	import mfmc_pkg::*;

	localparam int   STALL_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	int  mismatches, pending, pairs_seen, solves_seen;
	int  src_idle_pct = 20;
	int  snk_idle_pct = 71;
	bit  hold_sink = 1'b0;
	int  quiet_cycles = 0;
	int  cur_nodes = 16;

	always #4 clk = ~clk;

	max_flow_min_cut_edges u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	max_flow_min_cut_edges_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .pending(pending),
		.pairs_seen(pairs_seen), .solves_seen(solves_seen)
	);

	// receiver: random stalls, forced low during a hold-off
	always @(negedge clk) begin
		m_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// valid stays up after a transaction so the next one can follow at once
	task automatic send(input logic op, input logic [4:0] a, input logic [4:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'($urandom), 5'($urandom), b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_nodes(input int n);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (5000) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 5'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_nodes = (n < 2) ? 2 : (n > 16 ? 16 : n);
	endtask

	// mostly in-range nodes with a few unused, out-of-range and self loops
	task automatic random_graph(input int edges);
		int a, b;
		repeat (edges) begin
			a = $urandom_range(cur_nodes, 1);
			b = $urandom_range(cur_nodes, 1);
			if ($urandom_range(9) == 0) a = $urandom_range(31);
			send(OP_EDGE, 5'(a), 5'(b));
		end
		send(OP_SOLVE, 5'($urandom), 5'($urandom));
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty cut, chain, self loops, out-of-range ends, extremes
		send(OP_SOLVE, 5'd0, 5'd0);
		send(OP_EDGE, 5'd1, 5'd16);
		send(OP_EDGE, 5'd16, 5'd1);
		send(OP_EDGE, 5'd3, 5'd3);
		send(OP_EDGE, 5'd0, 5'd5);
		send(OP_EDGE, 5'd17, 5'd5);
		send(OP_EDGE, 5'd31, 5'd31);
		send(OP_EDGE, 5'd1, 5'd2);
		send(OP_SOLVE, 5'd31, 5'd31);
		set_nodes(2);
		send(OP_SOLVE, 5'd0, 5'd0);
		send(OP_EDGE, 5'd2, 5'd3);
		set_nodes(0);
		send(OP_SOLVE, 5'd0, 5'd0);
		set_nodes(31);
		send(OP_SOLVE, 5'd0, 5'd0);
		// stack parallel units on one pair
		set_nodes(3);
		repeat (6) send(OP_EDGE, 5'd1, 5'd2);
		send(OP_SOLVE, 5'd0, 5'd0);

		// random phases: pattern of idling changes
		set_nodes(5);
		random_graph(20);
		set_nodes(16);
		random_graph(25);
		src_idle_pct = 71; snk_idle_pct = 20;
		set_nodes(8);
		random_graph(20);
		set_nodes(12);
		random_graph(20);
		src_idle_pct = 0; snk_idle_pct = 0;
		set_nodes(16);
		// long hold-off: sink blocked while solves pile up
		fork
			begin
				hold_sink = 1'b1;
				repeat (20000) @(negedge clk);
				hold_sink = 1'b0;
			end
			begin
				random_graph(15);
				repeat (4) send(OP_SOLVE, 5'd0, 5'd0);
			end
		join
		set_nodes(2);
		random_graph(10);
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (5000) @(negedge clk);
		$display("covered %0d solves with %0d result transactions at node counts 0..31",
			solves_seen, pairs_seen);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/mfmc_pkg.sv
hw/rtl/mfmc_alu.sv
hw/rtl/mfmc_mat.sv
hw/rtl/max_flow_min_cut_edges.sv
hw/rtl/mfmc_chk.sv
tb/max_flow_min_cut_edges_checker.sv
tb/max_flow_min_cut_edges_test.sv
